@@ design/cbs_pkg.sv @@
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants for the B-spline path smoother
// Default sizes, weight format and the tag word that travels with a sample.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int SAMPLES_DEF = 20;
  localparam int COORD_DEF   = 32;

  // weights are unsigned Q0.16; one extra bit so that 1.0 fits
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int WGT_ONE  = 1 << FRAC_W;

  typedef struct packed {
    logic vld;
    logic run_last;
    logic path_done;
  } cbs_tag_t;

endpackage

@@ design/cbs_weights.sv @@
// ----------------------------------------------------------------------------
// cbs_weights: cubic B-spline basis weight table
// Four Q0.16 weights per sample index, built at elaboration.
// ----------------------------------------------------------------------------
module cbs_weights #(
  parameter int S = cbs_pkg::SAMPLES_DEF
) (
  input  logic [$clog2(S)-1:0]   k,
  output logic [cbs_pkg::WGT_W-1:0] w [4]
);
  import cbs_pkg::*;

  localparam longint SL = S;
  localparam longint D  = 6 * SL * SL * SL;

  logic [WGT_W-1:0] tbl [S][4];

  for (genvar kk = 0; kk < S; kk++) begin : g_k
    localparam longint K  = kk;
    localparam longint R  = SL - K;
    // round half up to Q0.16
    localparam longint W0 = (R * R * R * 131072 + D) / (2 * D);
    localparam longint W2 = ((-3 * K * K * K + 3 * K * K * SL + 3 * K * SL * SL
                              + SL * SL * SL) * 131072 + D) / (2 * D);
    localparam longint W3 = (K * K * K * 131072 + D) / (2 * D);
    // weight 1 absorbs the rounding so the four sum to exactly 1.0
    localparam longint W1 = WGT_ONE - W0 - W2 - W3;

    assign tbl[kk][0] = WGT_W'(W0);
    assign tbl[kk][1] = WGT_W'(W1);
    assign tbl[kk][2] = WGT_W'(W2);
    assign tbl[kk][3] = WGT_W'(W3);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = tbl[k][i];
    end
  end

endmodule

@@ design/cbs_seq.sv @@
// ----------------------------------------------------------------------------
// cbs_seq: waypoint window and sample sequencer
// Holds the last three waypoints, latches the control points of one job and
// issues one sample (control points, weights, tag) per advancing cycle.
// ----------------------------------------------------------------------------
module cbs_seq #(
  parameter int S  = cbs_pkg::SAMPLES_DEF,
  parameter int CW = cbs_pkg::COORD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CW-1:0]        in_point_x,
  input  logic signed [CW-1:0]        in_point_y,
  input  logic                        in_path_end,
  output cbs_pkg::cbs_tag_t           iss_tag,
  output logic signed [CW-1:0]        iss_x [4],
  output logic signed [CW-1:0]        iss_y [4],
  output logic [cbs_pkg::WGT_W-1:0]   iss_w [4]
);
  import cbs_pkg::*;

  localparam int KW = $clog2(S);
  localparam logic [1:0] SEEN_STREAM = 2'd3;
  localparam logic [1:0] RAW_LAST    = 2'd3;

  typedef enum logic [1:0] {PH_IDLE, PH_SEG_A, PH_SEG_B, PH_RAW} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        seen_r, seen_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [1:0]        raw_idx_r, raw_idx_nxt;
  logic              two_r, two_nxt;
  logic              end_r, end_nxt;
  logic signed [CW-1:0] win_x_r [3], win_x_nxt [3];
  logic signed [CW-1:0] win_y_r [3], win_y_nxt [3];
  logic signed [CW-1:0] jp_x_r [4], jp_x_nxt [4];
  logic signed [CW-1:0] jp_y_r [4], jp_y_nxt [4];

  logic              k_last;
  logic              fin_issue;
  logic              take;
  logic [WGT_W-1:0]  tbl_w [4];

  cbs_weights #(.S(S)) u_weights (
    .k (k_r),
    .w (tbl_w)
  );

  always_comb begin
    k_last    = (k_r == KW'(S - 1));
    fin_issue = ((phase_r == PH_SEG_A) && k_last && !two_r) ||
                ((phase_r == PH_RAW) && (raw_idx_r == RAW_LAST));
    in_stall  = !((phase_r == PH_IDLE) || (en && fin_issue));
    take      = in_valid && !in_stall;

    phase_nxt   = phase_r;
    seen_nxt    = seen_r;
    k_nxt       = k_r;
    raw_idx_nxt = raw_idx_r;
    two_nxt     = two_r;
    end_nxt     = end_r;
    win_x_nxt   = win_x_r;
    win_y_nxt   = win_y_r;
    jp_x_nxt    = jp_x_r;
    jp_y_nxt    = jp_y_r;

    if (en) begin
      case (phase_r)
        PH_SEG_A: begin
          if (k_last) begin
            k_nxt     = '0;
            phase_nxt = two_r ? PH_SEG_B : PH_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        PH_SEG_B: begin
          if (k_last) begin
            k_nxt       = '0;
            raw_idx_nxt = RAW_LAST;
            phase_nxt   = PH_RAW;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        PH_RAW: begin
          if (raw_idx_r == RAW_LAST) begin
            phase_nxt = PH_IDLE;
          end else begin
            raw_idx_nxt = raw_idx_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (take) begin
      // control points: p0 doubles the first point when the path starts
      jp_x_nxt[0] = (seen_r == 2'd2) ? win_x_r[1] : win_x_r[0];
      jp_y_nxt[0] = (seen_r == 2'd2) ? win_y_r[1] : win_y_r[0];
      jp_x_nxt[1] = win_x_r[1];
      jp_y_nxt[1] = win_y_r[1];
      jp_x_nxt[2] = win_x_r[2];
      jp_y_nxt[2] = win_y_r[2];
      jp_x_nxt[3] = in_point_x;
      jp_y_nxt[3] = in_point_y;
      end_nxt     = in_path_end;
      k_nxt       = '0;
      two_nxt     = in_path_end;

      if (in_path_end && (seen_r != SEEN_STREAM)) begin
        // short path: held points then the new one, raw
        phase_nxt   = PH_RAW;
        raw_idx_nxt = RAW_LAST - seen_r;
      end else if (seen_r >= 2'd2) begin
        phase_nxt = PH_SEG_A;
      end else begin
        phase_nxt = PH_IDLE;
      end

      win_x_nxt[0] = win_x_r[1];
      win_x_nxt[1] = win_x_r[2];
      win_x_nxt[2] = in_point_x;
      win_y_nxt[0] = win_y_r[1];
      win_y_nxt[1] = win_y_r[2];
      win_y_nxt[2] = in_point_y;

      if (in_path_end) begin
        seen_nxt = '0;
      end else if (seen_r != SEEN_STREAM) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  // issue word for the blend pipeline
  always_comb begin
    iss_tag.vld       = (phase_r != PH_IDLE);
    iss_tag.run_last  = fin_issue;
    iss_tag.path_done = fin_issue && end_r;
    iss_w             = tbl_w;
    iss_x             = jp_x_r;
    iss_y             = jp_y_r;
    case (phase_r)
      PH_SEG_B: begin
        iss_x[0] = jp_x_r[1];
        iss_x[1] = jp_x_r[2];
        iss_x[2] = jp_x_r[3];
        iss_y[0] = jp_y_r[1];
        iss_y[1] = jp_y_r[2];
        iss_y[2] = jp_y_r[3];
      end
      PH_RAW: begin
        // raw point goes through slot 1 at weight 1.0; other slots may hold
        // points never written on a short path, so they are zeroed
        iss_x    = '{default: '0};
        iss_y    = '{default: '0};
        iss_x[1] = jp_x_r[raw_idx_r];
        iss_y[1] = jp_y_r[raw_idx_r];
        iss_w[0] = '0;
        iss_w[1] = WGT_W'(WGT_ONE);
        iss_w[2] = '0;
        iss_w[3] = '0;
      end
      default: begin
        iss_x = jp_x_r;
        iss_y = jp_y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
    end
    k_r       <= k_nxt;
    raw_idx_r <= raw_idx_nxt;
    two_r     <= two_nxt;
    end_r     <= end_nxt;
    win_x_r   <= win_x_nxt;
    win_y_r   <= win_y_nxt;
    jp_x_r    <= jp_x_nxt;
    jp_y_r    <= jp_y_nxt;
  end

endmodule

@@ design/cbs_blend.sv @@
// ----------------------------------------------------------------------------
// cbs_blend: weighted sum of four control points, x and y
// Stage 1 registers the products, stage 2 sums, rounds half up to Q.16 and
// saturates into the output register.
// ----------------------------------------------------------------------------
module cbs_blend #(
  parameter int CW = cbs_pkg::COORD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cbs_pkg::cbs_tag_t         iss_tag,
  input  logic signed [CW-1:0]      iss_x [4],
  input  logic signed [CW-1:0]      iss_y [4],
  input  logic [cbs_pkg::WGT_W-1:0] iss_w [4],
  output cbs_pkg::cbs_tag_t         res_tag,
  output logic signed [CW-1:0]      res_x,
  output logic signed [CW-1:0]      res_y
);
  import cbs_pkg::*;

  localparam int PW = CW + WGT_W + 1;
  localparam int SW = PW + 2;
  localparam int QW = SW - FRAC_W;
  localparam logic signed [SW-1:0] RND  = SW'(1) <<< (FRAC_W - 1);
  localparam logic signed [QW-1:0] QMAX = {{(QW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {{(QW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  cbs_tag_t             tag1_r, tag2_r;
  logic signed [PW-1:0] prod_x_r [4];
  logic signed [PW-1:0] prod_y_r [4];
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [QW-1:0] q_x, q_y;
  logic signed [CW-1:0] sat_x, sat_y;
  logic signed [CW-1:0] res_x_r, res_y_r;

  function automatic logic signed [CW-1:0] sat(input logic signed [QW-1:0] q);
    logic signed [CW-1:0] r;
    if (q > QMAX) begin
      r = {1'b0, {(CW - 1){1'b1}}};
    end else if (q < QMIN) begin
      r = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      r = q[CW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sum_x = RND;
    sum_y = RND;
    for (int i = 0; i < 4; i++) begin
      sum_x = sum_x + SW'(prod_x_r[i]);
      sum_y = sum_y + SW'(prod_y_r[i]);
    end
    q_x   = sum_x[SW-1:FRAC_W];
    q_y   = sum_y[SW-1:FRAC_W];
    sat_x = sat(q_x);
    sat_y = sat(q_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (en) begin
      tag1_r <= iss_tag;
      tag2_r <= tag1_r;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod_x_r[i] <= iss_x[i] * $signed({1'b0, iss_w[i]});
        prod_y_r[i] <= iss_y[i] * $signed({1'b0, iss_w[i]});
      end
      res_x_r <= sat_x;
      res_y_r <= sat_y;
    end
  end

  assign res_tag = tag2_r;
  assign res_x   = res_x_r;
  assign res_y   = res_y_r;

endmodule

@@ design/cubic_bspline_path_smoother.sv @@
// ----------------------------------------------------------------------------
// cubic_bspline_path_smoother: uniform cubic B-spline waypoint smoother
// Takes waypoints, emits smoothed path samples in signed Q15.16.
// ----------------------------------------------------------------------------
// Input words carry one waypoint (x, y) and a path-end flag. Output words
// carry one sample, run_last on the final word caused by an input word, and
// path_done on the final word of the path. Both channels use valid/stall.
// The first two waypoints of a path are buffered and produce nothing; each
// later interior waypoint produces S samples; the end waypoint of a long path
// produces 2*S samples plus the raw end point; a path of one to three points
// comes back raw when its end arrives.
// An input word occupies the sequencer until its output words have issued;
// a new word is taken in the cycle its last sample issues or while the
// sequencer is idle. One sample per cycle unless out_stall holds the
// pipeline, set by the sequencer issuing one weight set per cycle into a
// two-stage multiply/sum pipeline fed from the control-point registers.
// Reset clears the sequencer and the point count; a new path starts.
// While an output word waits under out_stall the blend pipeline and sample
// issue hold; in_stall is high while the sequencer still has samples of an
// earlier word to issue, including its last one during such a hold.
// ----------------------------------------------------------------------------
module cubic_bspline_path_smoother #(
  parameter int SAMPLES_PER_SEGMENT = cbs_pkg::SAMPLES_DEF,
  parameter int COORD_WIDTH         = cbs_pkg::COORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_path_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_sample_x,
  output logic signed [COORD_WIDTH-1:0] out_sample_y,
  output logic                          out_run_last,
  output logic                          out_path_done
);
  import cbs_pkg::*;

  logic                         en;
  cbs_tag_t                     iss_tag;
  cbs_tag_t                     res_tag;
  logic signed [COORD_WIDTH-1:0] iss_x [4];
  logic signed [COORD_WIDTH-1:0] iss_y [4];
  logic [WGT_W-1:0]             iss_w [4];

  // pipeline advances unless a finished word is held by the receiver
  assign en = !(res_tag.vld && out_stall);

  cbs_seq #(
    .S  (SAMPLES_PER_SEGMENT),
    .CW (COORD_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_path_end (in_path_end),
    .iss_tag     (iss_tag),
    .iss_x       (iss_x),
    .iss_y       (iss_y),
    .iss_w       (iss_w)
  );

  cbs_blend #(
    .CW (COORD_WIDTH)
  ) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .iss_tag (iss_tag),
    .iss_x   (iss_x),
    .iss_y   (iss_y),
    .iss_w   (iss_w),
    .res_tag (res_tag),
    .res_x   (out_sample_x),
    .res_y   (out_sample_y)
  );

  assign out_valid     = res_tag.vld;
  assign out_run_last  = res_tag.run_last;
  assign out_path_done = res_tag.path_done;

endmodule

@@ test/tb_cubic_bspline_path_smoother.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubic_bspline_path_smoother: self-checking bench for the path smoother
// Drives waypoint paths (short pass-through paths, long paths with extreme
// and random coordinates), predicts every sample from its own B-spline
// blend, and checks each output word in order, with random idling on both
// channels except in the final stretch.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_path_smoother;
  import cbs_pkg::*;

  localparam int SEG = SAMPLES_DEF;
  localparam int CW  = COORD_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [1:0] HELD_STREAMING = 2'd3;
  localparam longint C_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint C_MIN = -(longint'(1) <<< (CW - 1));

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   run_last;
    logic   path_done;
  } sample_t;

  typedef enum int {COORD_FULL, COORD_NEAR, COORD_EDGE} coord_style_t;

  localparam coord_t C_TOP = coord_t'(C_MAX);
  localparam coord_t C_BOT = coord_t'(C_MIN);

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  coord_t in_point_x;
  coord_t in_point_y;
  logic   in_path_end;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_sample_x;
  coord_t out_sample_y;
  logic   out_run_last;
  logic   out_path_done;

  cubic_bspline_path_smoother uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_path_end  (in_path_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample_x (out_sample_x),
    .out_sample_y (out_sample_y),
    .out_run_last (out_run_last),
    .out_path_done(out_path_done)
  );

  // predictor state
  coord_t     win_x [3];
  coord_t     win_y [3];
  logic [1:0] points_held;
  sample_t    path_batch[$];
  sample_t    pending_samples[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_en = 1'b1;
  sample_t want;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------- predictor ----------------
  function automatic longint round_q16(longint num, longint den);
    return (num * 2 * WGT_ONE + den) / (2 * den);
  endfunction

  function automatic coord_t blend_coord(int k, coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    longint s, kk, d, r, w0, w1, w2, w3, acc, q;
    s  = SEG;
    kk = k;
    d  = 6 * s * s * s;
    r  = s - kk;
    w0 = round_q16(r * r * r, d);
    w2 = round_q16(-3 * kk * kk * kk + 3 * kk * kk * s + 3 * kk * s * s + s * s * s, d);
    w3 = round_q16(kk * kk * kk, d);
    w1 = WGT_ONE - w0 - w2 - w3;
    acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    q = (acc + WGT_ONE / 2) >>> FRAC_W;  // round half up
    if (q > C_MAX) q = C_MAX;
    if (q < C_MIN) q = C_MIN;
    return coord_t'(q);
  endfunction

  task automatic push_raw(coord_t px, coord_t py);
    sample_t s;
    s.x = px;
    s.y = py;
    s.run_last = 1'b0;
    s.path_done = 1'b0;
    path_batch = {path_batch, s};
  endtask

  task automatic push_segment(coord_t a0, coord_t a1, coord_t a2, coord_t a3,
                              coord_t b0, coord_t b1, coord_t b2, coord_t b3);
    sample_t s;
    for (int k = 0; k < SEG; k++) begin
      s.x = blend_coord(k, a0, a1, a2, a3);
      s.y = blend_coord(k, b0, b1, b2, b3);
      s.run_last = 1'b0;
      s.path_done = 1'b0;
      path_batch = {path_batch, s};
    end
  endtask

  task automatic predict_point(coord_t px, coord_t py, logic last);
    logic [1:0] c;
    sample_t tail;
    c = points_held;
    path_batch.delete();
    if (c != HELD_STREAMING && last) begin
      // short path: held points and the end point come back raw
      for (int i = 3 - int'(c); i < 3; i++) push_raw(win_x[i], win_y[i]);
      push_raw(px, py);
    end else if (c == 2'd2) begin
      push_segment(win_x[1], win_x[1], win_x[2], px, win_y[1], win_y[1], win_y[2], py);
    end else if (c == HELD_STREAMING) begin
      push_segment(win_x[0], win_x[1], win_x[2], px, win_y[0], win_y[1], win_y[2], py);
      if (last) begin
        push_segment(win_x[1], win_x[2], px, px, win_y[1], win_y[2], py, py);
        push_raw(px, py);
      end
    end
    win_x[0] = win_x[1];
    win_x[1] = win_x[2];
    win_x[2] = px;
    win_y[0] = win_y[1];
    win_y[1] = win_y[2];
    win_y[2] = py;
    if (last) points_held = 2'd0;
    else if (c != HELD_STREAMING) points_held = c + 2'd1;
    if (path_batch.size() > 0) begin
      tail = path_batch.pop_back();
      tail.run_last = 1'b1;
      tail.path_done = last;
      path_batch = {path_batch, tail};
    end
    pending_samples = {pending_samples, path_batch};
  endtask

  // ---------------- checking ----------------
  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected word x=%h y=%h last=%b done=%b",
                                out_sample_x, out_sample_y, out_run_last, out_path_done));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_x !== want.x || out_sample_y !== want.y ||
            out_run_last !== want.run_last || out_path_done !== want.path_done) begin
          flag_mismatch($sformatf(
            "sample mismatch: want x=%h y=%h last=%b done=%b, got x=%h y=%h last=%b done=%b",
            want.x, want.y, want.run_last, want.path_done,
            out_sample_x, out_sample_y, out_run_last, out_path_done));
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls in bursts; stall_left counts down the rest of a burst
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- stimulus ----------------
  // entered and left at a falling edge; valid stays high between back-to-back words
  task automatic send_point(coord_t px, coord_t py, logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_path_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_point(px, py, last);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord(coord_style_t style);
    case (style)
      COORD_FULL: return coord_t'($urandom);
      COORD_NEAR: return coord_t'(int'($urandom_range(0, 33554431)) - 16777215);
      default: begin
        case ($urandom_range(0, 3))
          0: return C_TOP;
          1: return C_BOT;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_paths(int count);
    int sent;
    int len;
    coord_style_t style;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range(4, 12);
      style = coord_style_t'($urandom_range(0, 2));
      for (int i = 0; i < len; i++) begin
        send_point(rand_coord(style), rand_coord(style), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_short_paths();
    send_point(C_TOP, C_BOT, 1'b1);
    send_point('0, '0, 1'b0);
    send_point(C_BOT, C_TOP, 1'b1);
    send_point('1, 32'sd1, 1'b0);
    send_point(C_TOP, '0, 1'b0);
    send_point(C_BOT, '1, 1'b1);
  endtask

  task automatic test_extreme_long_paths();
    // minimal long path, corners of the coordinate range
    send_point(C_TOP, C_BOT, 1'b0);
    send_point(C_BOT, C_TOP, 1'b0);
    send_point(C_TOP, C_TOP, 1'b0);
    send_point(C_BOT, C_BOT, 1'b1);
    // small values to exercise rounding near zero
    send_point(32'sd1, -32'sd1, 1'b0);
    send_point(-32'sd3, 32'sd3, 1'b0);
    send_point(32'sd65536, -32'sd65536, 1'b0);
    send_point('1, '0, 1'b0);
    send_point(32'sd32767, -32'sd32768, 1'b0);
    send_point(32'sd5, 32'sd7, 1'b1);
  endtask

  task automatic test_random_paths();
    send_random_paths(230);
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    send_random_paths(30);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_path_end = 1'b0;
    points_held = 2'd0;
    for (int i = 0; i < 3; i++) begin
      win_x[i] = '0;
      win_y[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_paths();
    test_extreme_long_paths();
    test_random_paths();
    test_steady_stream();

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cbs_pkg.sv
design/cbs_weights.sv
design/cbs_seq.sv
design/cbs_blend.sv
design/cubic_bspline_path_smoother.sv
test/tb_cubic_bspline_path_smoother.sv
